>>> src/tps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_pkg
// Shared widths, constants and types of the timer prescaler setup unit.
// ----------------------------------------------------------------------------
package tps_pkg;

    // configuration and divider widths
    localparam int CLK_W      = 32;
    localparam int TICK_W     = 20;
    localparam int REF_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // base tick rate of 1 MHz
    localparam logic [TICK_W-1:0] TICK_HZ   = TICK_W'(1000000);
    localparam int                CROP_BITS = 15;

    // prescale limits with and without the primary prescaler
    localparam logic [CLK_W-1:0] MAX_PRESCALE    = CLK_W'(256 * 256 * 16);
    localparam logic [CLK_W-1:0] MAX_PRESCALE_NP = CLK_W'(256 * 16);
    localparam logic [CLK_W-1:0] PRESCALE_BYPASS = CLK_W'(256);

    // clock source codes
    localparam logic [1:0] CLK_OFF    = 2'd0;
    localparam logic [1:0] CLK_NORMAL = 2'd1;
    localparam logic [1:0] CLK_SLOWGO = 2'd2;

    // mode word flags
    localparam logic [15:0] MODE_RESTART = 16'h0008;
    localparam logic [15:0] MODE_IRQ_EN  = 16'h0010;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_CLOCK_HZ = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HAS_PRIMARY    = CFG_IDX_W'(1);

    // item fields that ride alongside the divider
    typedef struct packed {
        logic [REF_W-1:0] ref_count;
        logic             restart;
        logic             tick_zero;
    } t_side;

endpackage

>>> src/tps_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_in_if
// Request channel: interval, precision mode and restart flag.
// ----------------------------------------------------------------------------
interface tps_in_if #(
    parameter int INTERVAL_BITS = 32
);
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [INTERVAL_BITS-1:0] interval_us;
    logic                     restart_on_match;

    modport source (output valid, func, interval_us, restart_on_match, input ready);
    modport sink   (input valid, func, interval_us, restart_on_match, output ready);
endinterface

>>> src/tps_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_out_if
// Result channel: timer settings for one request.
// ----------------------------------------------------------------------------
interface tps_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [1:0]  clock_select;
    logic [7:0]  primary_prescale;
    logic [7:0]  secondary_prescale;
    logic [15:0] mode_word;
    logic [15:0] reference_count;

    modport source (output valid, status, clock_select, primary_prescale,
                    secondary_prescale, mode_word, reference_count, input ready);
    modport sink   (input valid, status, clock_select, primary_prescale,
                    secondary_prescale, mode_word, reference_count, output ready);
endinterface

>>> src/tps_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tps_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/tps_crop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_crop
// Front end: finds the top set bit of the interval, crops it to 15 bits in
// cropped mode and lowers the tick rate by the same shift.
// ----------------------------------------------------------------------------
module tps_crop
    import tps_pkg::*;
#(
    parameter int INTERVAL_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_valid,
    input  logic                     i_func,
    input  logic [INTERVAL_BITS-1:0] i_interval,
    input  logic                     i_restart,
    output logic                     o_valid,
    output logic [TICK_W-1:0]        o_divisor,
    output t_side                    o_side
);
    localparam int BW = $clog2(INTERVAL_BITS + 1);

    logic                     r1_valid;
    logic                     r1_exact;
    logic                     r1_restart;
    logic [INTERVAL_BITS-1:0] r1_usec;
    logic [BW-1:0]            r1_top;
    logic [BW-1:0]            n1_top;

    logic                     r2_valid;
    logic [TICK_W-1:0]        r2_divisor;
    t_side                    r2_side;
    logic [BW-1:0]            n2_shift;
    logic [INTERVAL_BITS-1:0] n2_usec;
    t_side                    n2_side;

    // position of the highest set bit, counted from one
    always_comb begin
        n1_top = '0;
        for (int i = 0; i < INTERVAL_BITS; i++) begin
            if (i_interval[i]) begin
                n1_top = BW'(i + 1);
            end
        end
    end

    // stage one: capture request and top bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
        end
        if (i_adv) begin
            r1_exact   <= i_func;
            r1_restart <= i_restart;
            r1_usec    <= i_interval;
            r1_top     <= n1_top;
        end
    end

    // cropping shift and reduced tick rate
    always_comb begin
        if (!r1_exact && (r1_top > BW'(CROP_BITS))) begin
            n2_shift = r1_top - BW'(CROP_BITS);
        end else begin
            n2_shift = '0;
        end
        n2_usec = r1_usec >> n2_shift;
        if (r1_exact) begin
            n2_side.ref_count = r1_usec[REF_W-1:0];
        end else begin
            n2_side.ref_count = n2_usec[REF_W-1:0];
        end
        n2_side.restart   = r1_restart;
        n2_side.tick_zero = (n2_shift >= BW'(TICK_W));
    end

    // stage two: divisor and side fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r2_valid <= r1_valid;
        end
        if (i_adv) begin
            r2_divisor <= TICK_HZ >> n2_shift;
            r2_side    <= n2_side;
        end
    end

    assign o_valid   = r2_valid;
    assign o_divisor = r2_divisor;
    assign o_side    = r2_side;

endmodule

>>> src/tps_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_div_cell
// One restoring divider cell: settles one quotient bit and hands the
// partial remainder, the rest of the dividend and the item on.
// ----------------------------------------------------------------------------
module tps_div_cell
    import tps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [TICK_W-1:0] i_rem,
    input  logic [CLK_W-1:0]  i_num,
    input  logic [CLK_W-1:0]  i_quo,
    input  logic [TICK_W-1:0] i_div,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [TICK_W-1:0] o_rem,
    output logic [CLK_W-1:0]  o_num,
    output logic [CLK_W-1:0]  o_quo,
    output logic [TICK_W-1:0] o_div,
    output t_side             o_side
);
    logic              r_valid;
    logic [TICK_W-1:0] r_rem;
    logic [CLK_W-1:0]  r_num;
    logic [CLK_W-1:0]  r_quo;
    logic [TICK_W-1:0] r_div;
    t_side             r_side;

    logic [TICK_W:0]   n_partial;
    logic [TICK_W:0]   n_diff;
    logic              n_ge;
    logic [TICK_W-1:0] n_rem;

    // bring down the next dividend bit and trial subtract
    always_comb begin
        n_partial = {i_rem, i_num[CLK_W-1]};
        n_diff    = n_partial - {1'b0, i_div};
        n_ge      = (n_partial >= {1'b0, i_div});
        n_rem     = n_ge ? n_diff[TICK_W-1:0] : n_partial[TICK_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_rem  <= n_rem;
            r_num  <= {i_num[CLK_W-2:0], 1'b0};
            r_quo  <= {i_quo[CLK_W-2:0], n_ge};
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_quo   = r_quo;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

>>> src/timer_prescaler_setup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_prescaler_setup_unit
// Turns a requested interval into prescaler, clock source, mode word and
// reference settings for a 16-bit timer.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  i_in     | in        | func, interval_us, restart_on_match
//  o_out    | out       | status, clock_select, prescalers, mode_word, ref
//  i_cfg    | in        | register index, write data (always ready)
//
//  One item per cycle while the chain is not held; two cropping stages, a chain of
//  32 divider cells (one quotient bit each) and the output register.
//  Reset clears all valid bits and loads the register reset values.
//  When the output register is full and not taken, the whole chain holds
//  and i_in.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module timer_prescaler_setup_unit
    import tps_pkg::*;
#(
    parameter int INTERVAL_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tps_in_if.sink    i_in,
    tps_out_if.source o_out,
    tps_cfg_if.sink   i_cfg
);
    logic [CLK_W-1:0] r_clock_hz;
    logic             r_has_primary;

    logic             w_adv;

    logic              c_valid [0:CLK_W];
    logic [TICK_W-1:0] c_rem   [0:CLK_W];
    logic [CLK_W-1:0]  c_num   [0:CLK_W];
    logic [CLK_W-1:0]  c_quo   [0:CLK_W];
    logic [TICK_W-1:0] c_div   [0:CLK_W];
    t_side             c_side  [0:CLK_W];

    logic [CLK_W-1:0] n_maxp;
    logic [CLK_W-1:0] n_presc;
    logic             n_err;
    logic             n_slow;
    logic [1:0]       n_clk;
    logic [7:0]       n_pri;
    logic [7:0]       n_sec;

    logic             r_out_valid;
    logic             r_status;
    logic [1:0]       r_clock_select;
    logic [7:0]       r_primary;
    logic [7:0]       r_secondary;
    logic [15:0]      r_mode_word;
    logic [15:0]      r_reference;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz    <= '0;
            r_has_primary <= 1'b1;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_INPUT_CLOCK_HZ) begin
                r_clock_hz <= i_cfg.data[CLK_W-1:0];
            end else if (i_cfg.index == REG_HAS_PRIMARY) begin
                r_has_primary <= i_cfg.data[0];
            end
        end
    end

    // the chain moves whenever the output register can take an item
    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv;

    // crop interval and derive the tick divisor
    tps_crop #(
        .INTERVAL_BITS(INTERVAL_BITS)
    ) u_crop (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_valid    (i_in.valid),
        .i_func     (i_in.func),
        .i_interval (i_in.interval_us),
        .i_restart  (i_in.restart_on_match),
        .o_valid    (c_valid[0]),
        .o_divisor  (c_div[0]),
        .o_side     (c_side[0])
    );

    // dividend enters at the head of the divider chain
    assign c_rem[0] = '0;
    assign c_num[0] = r_clock_hz;
    assign c_quo[0] = '0;

    // divider chain, one cell per quotient bit
    for (genvar k = 0; k < CLK_W; k++) begin : g_cell
        tps_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (c_valid[k]),
            .i_rem   (c_rem[k]),
            .i_num   (c_num[k]),
            .i_quo   (c_quo[k]),
            .i_div   (c_div[k]),
            .i_side  (c_side[k]),
            .o_valid (c_valid[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_num   (c_num[k+1]),
            .o_quo   (c_quo[k+1]),
            .o_div   (c_div[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    // split the prescale into slow-go, primary and secondary stages
    always_comb begin
        n_maxp = r_has_primary ? MAX_PRESCALE : MAX_PRESCALE_NP;
        n_err  = c_side[CLK_W].tick_zero || (c_quo[CLK_W] > n_maxp);
        n_slow = c_quo[CLK_W] > (n_maxp >> 4);
        n_presc = n_slow ? (c_quo[CLK_W] >> 4) : c_quo[CLK_W];
        n_clk   = n_slow ? CLK_SLOWGO : CLK_NORMAL;
        if (n_presc <= PRESCALE_BYPASS) begin
            n_pri = 8'd0;
            n_sec = n_presc[7:0] - 8'd1;
        end else begin
            n_pri = 8'd255;
            n_sec = n_presc[15:8] - 8'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= c_valid[CLK_W];
        end
        if (w_adv) begin
            if (n_err) begin
                r_status       <= 1'b1;
                r_clock_select <= CLK_OFF;
                r_primary      <= 8'd0;
                r_secondary    <= 8'd0;
                r_mode_word    <= 16'd0;
                r_reference    <= 16'd0;
            end else begin
                r_status       <= 1'b0;
                r_clock_select <= n_clk;
                r_primary      <= n_pri;
                r_secondary    <= n_sec;
                r_mode_word    <= {n_sec, 8'd0} | MODE_IRQ_EN
                                | (c_side[CLK_W].restart ? MODE_RESTART : 16'd0)
                                | {13'd0, n_clk, 1'b0};
                r_reference    <= c_side[CLK_W].ref_count;
            end
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.status             = r_status;
    assign o_out.clock_select       = r_clock_select;
    assign o_out.primary_prescale   = r_primary;
    assign o_out.secondary_prescale = r_secondary;
    assign o_out.mode_word          = r_mode_word;
    assign o_out.reference_count    = r_reference;

endmodule

>>> tb/sv/timer_prescaler_setup_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_prescaler_setup_unit_tb
// Drives interval requests under several clock and prescaler settings and
// checks every returned timer setting against an in-bench calculation, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module timer_prescaler_setup_unit_tb;
    import tps_pkg::*;

    localparam int INTERVAL_BITS = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idling_t;

    typedef struct packed {
        logic                     func;
        logic [INTERVAL_BITS-1:0] interval_us;
        logic                     restart;
    } interval_req_t;

    typedef struct packed {
        logic        status;
        logic [1:0]  clock_select;
        logic [7:0]  primary_prescale;
        logic [7:0]  secondary_prescale;
        logic [15:0] mode_word;
        logic [15:0] reference_count;
    } timer_setting_t;

    logic i_clk;
    logic i_rst_n;

    tps_in_if #(.INTERVAL_BITS(INTERVAL_BITS)) in_bus ();
    tps_out_if                                 out_bus ();
    tps_cfg_if                                 cfg_bus ();

    timer_prescaler_setup_unit #(
        .INTERVAL_BITS(INTERVAL_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus),
        .i_cfg  (cfg_bus)
    );

    // bench copy of the configuration registers
    logic [CLK_W-1:0] clock_hz;
    logic             has_primary;

    interval_req_t  request_q [$];
    timer_setting_t setting_q [$];

    int  send_idle_pct;
    int  stall_pct;
    bit  hold_req;
    int  hold_left;
    bit  req_taken;
    int  fail_count;
    int  quiet_cycles;

    // timer settings for one request under the current configuration
    function automatic timer_setting_t timer_setting_for(logic func,
                                                         logic [INTERVAL_BITS-1:0] interval,
                                                         logic restart);
        logic [INTERVAL_BITS-1:0] usec;
        logic [TICK_W-1:0]        tick;
        logic [CLK_W-1:0]         limit;
        logic [CLK_W-1:0]         presc;
        int                       width;
        timer_setting_t           s;
        usec  = interval;
        tick  = TICK_HZ;
        width = 0;
        s     = '0;
        // exact mode keeps 16 bits, cropped mode scales wide intervals down
        if (func) begin
            usec = usec & INTERVAL_BITS'(16'hFFFF);
        end else begin
            for (int k = 0; k < INTERVAL_BITS; k++) begin
                if (usec[k]) begin
                    width = k + 1;
                end
            end
            if (width > CROP_BITS) begin
                tick = tick >> (width - CROP_BITS);
                usec = usec >> (width - CROP_BITS);
            end
        end
        limit = has_primary ? MAX_PRESCALE : MAX_PRESCALE_NP;
        presc = clock_hz / CLK_W'(tick);
        if (tick == '0 || presc > limit) begin
            s.status = 1'b1;
            return s;
        end
        s.clock_select = CLK_NORMAL;
        if (presc > limit / 16) begin
            s.clock_select = CLK_SLOWGO;
            presc          = presc / 16;
        end
        // small prescale goes to the secondary stage alone
        if (presc <= PRESCALE_BYPASS) begin
            s.primary_prescale   = 8'd0;
            s.secondary_prescale = 8'(presc - 1);
        end else begin
            s.primary_prescale   = 8'd255;
            s.secondary_prescale = 8'(presc / 256 - 1);
        end
        s.mode_word = {s.secondary_prescale, 8'h00} | {13'd0, s.clock_select, 1'b0}
                    | MODE_IRQ_EN | (restart ? MODE_RESTART : 16'h0000);
        s.reference_count = usec[15:0];
        return s;
    endfunction

    // clock generation
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // request driver
    always @(negedge i_clk) begin
        interval_req_t req;
        if (i_rst_n && (!in_bus.valid || req_taken)) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req = request_q.pop_front();
                in_bus.valid            <= 1'b1;
                in_bus.func             <= req.func;
                in_bus.interval_us      <= req.interval_us;
                in_bus.restart_on_match <= req.restart;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        timer_setting_t got;
        timer_setting_t want;
        bit             bad;
        req_taken <= in_bus.valid && in_bus.ready;
        if (cfg_bus.valid && cfg_bus.ready) begin
            if (cfg_bus.index == REG_INPUT_CLOCK_HZ) begin
                clock_hz = cfg_bus.data;
            end else if (cfg_bus.index == REG_HAS_PRIMARY) begin
                has_primary = cfg_bus.data[0];
            end
        end
        if (in_bus.valid && in_bus.ready) begin
            setting_q.push_back(timer_setting_for(in_bus.func, in_bus.interval_us,
                                                  in_bus.restart_on_match));
        end
        if (out_bus.valid && out_bus.ready) begin
            got = '{out_bus.status, out_bus.clock_select, out_bus.primary_prescale,
                    out_bus.secondary_prescale, out_bus.mode_word, out_bus.reference_count};
            if (setting_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: result with no request pending: %p", $realtime, got);
                end
            end else begin
                want = setting_q.pop_front();
                bad  = (got.status !== want.status)
                    || (got.clock_select !== want.clock_select)
                    || (got.primary_prescale !== want.primary_prescale)
                    || (got.secondary_prescale !== want.secondary_prescale)
                    || (got.mode_word !== want.mode_word)
                    || (got.reference_count !== want.reference_count);
                if (bad) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: setting mismatch\n  expected %p\n  actual   %p",
                                 $realtime, want, got);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_request(logic func, logic [INTERVAL_BITS-1:0] interval, logic restart);
        interval_req_t req;
        req.func        = func;
        req.interval_us = interval;
        req.restart     = restart;
        request_q.push_back(req);
    endtask

    // random intervals mostly spread evenly over their highest set bit, one in eight fully random
    task automatic push_random(int count);
        int                       width;
        logic [INTERVAL_BITS-1:0] interval;
        for (int n = 0; n < count; n++) begin
            width = $urandom_range(INTERVAL_BITS, 0);
            if ($urandom_range(7) == 0) begin
                interval = $urandom;
            end else if (width == 0) begin
                interval = '0;
            end else begin
                interval = ($urandom >> (32 - width))
                         | (INTERVAL_BITS'(1) << (width - 1));
            end
            push_request(1'($urandom_range(1)), interval, 1'($urandom_range(1)));
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = index;
        cfg_bus.data  = data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic configure(logic [CLK_W-1:0] clock, logic primary);
        write_reg(REG_INPUT_CLOCK_HZ, clock);
        write_reg(REG_HAS_PRIMARY, ($urandom & ~32'h1) | CFG_DATA_W'(primary));
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || in_bus.valid || setting_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_idling(idling_t mode);
        send_idle_pct = (mode == IDLE_SENDER) ? 87 : (mode == IDLE_BOTH) ? 32 : 0;
        stall_pct     = (mode == IDLE_RECEIVER) ? 87 : (mode == IDLE_BOTH) ? 32 : 0;
    endtask

    // stimulus sequence
    initial begin
        logic [INTERVAL_BITS-1:0] edge_intervals [10];
        logic [CLK_W-1:0]         clock;
        logic                     primary;
        edge_intervals = '{32'h0000_0000, 32'h0000_0001, 32'h0000_7FFF, 32'h0000_8000,
                           32'h0000_FFFF, 32'h0001_0000, 32'h0004_0000, 32'h8000_0000,
                           32'hFFFF_FFFF, 32'hAAAA_5555};
        i_rst_n                 = 1'b0;
        in_bus.valid            = 1'b0;
        in_bus.func             = 1'b0;
        in_bus.interval_us      = '0;
        in_bus.restart_on_match = 1'b0;
        out_bus.ready           = 1'b1;
        cfg_bus.valid           = 1'b0;
        cfg_bus.index           = '0;
        cfg_bus.data            = '0;
        clock_hz                = '0;
        has_primary             = 1'b1;
        hold_req                = 1'b0;
        hold_left               = 0;
        req_taken               = 1'b0;
        fail_count              = 0;
        quiet_cycles            = 0;
        set_idling(IDLE_NONE);
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset configuration: zero input clock wraps the secondary stage
        push_request(1'b0, 32'h0000_1234, 1'b1);
        push_request(1'b1, 32'hFFFF_FFFF, 1'b0);
        push_request(1'b0, 32'hFFFF_FFFF, 1'b0);
        wait_drained();

        // edge intervals with the fastest clock, then without the primary stage
        configure(32'hFFFF_FFFF, 1'b1);
        for (int k = 0; k < 10; k++) begin
            push_request(k[0], edge_intervals[k], k[1]);
        end
        wait_drained();
        configure(32'd100_000_000, 1'b0);
        for (int k = 0; k < 10; k++) begin
            push_request(~k[0], edge_intervals[k], ~k[1]);
        end
        wait_drained();

        // random phases over clock settings and idling patterns
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin clock = 32'hFFFF_FFFF;     primary = 1'b1; end
                1: begin clock = 32'd0;             primary = 1'b0; end
                2: begin clock = 32'd999_999;       primary = 1'b1; end
                3: begin clock = 32'd1_000_000;     primary = 1'b0; end
                5: begin clock = 32'd100_000_000;   primary = 1'b0; end
                7: begin clock = 32'd4_096_000_000; primary = 1'b1; end
                default: begin
                    clock   = $urandom >> $urandom_range(31, 0);
                    primary = (phase == 4) ? 1'b1 : 1'(($urandom_range(1)));
                end
            endcase
            set_idling(idling_t'(phase % 4));
            configure(clock, primary);
            if (phase == 3) begin
                write_reg(REG_SPARE_2, $urandom);
                write_reg(REG_SPARE_3, $urandom);
            end
            if (phase == 4) begin
                hold_req = 1'b1;
            end
            if (phase == 5) begin
                // sender stops until every result is back, then resumes
                push_random(96);
                wait_drained();
                push_random(96);
            end else begin
                push_random(192);
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && setting_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
